@@ design/rlbc_pkg.sv @@
// shared types and constants for the run-length byte compressor
`default_nettype none

package rlbc_pkg;

    localparam int RunLenW    = 4;
    localparam int ByteW      = 8;
    localparam int ListDepth  = 4;
    localparam int CountW     = 3;
    localparam int ThrW       = 3;
    localparam int MaxRunDef  = 9;

    localparam logic [RunLenW-1:0] RunCap       = 4'd15;
    localparam logic [RunLenW-1:0] MinRunReset  = 4'd4;
    localparam logic [RunLenW-1:0] ThrFloor     = 4'd2;
    localparam logic [RunLenW-1:0] ThrCeil      = 4'd4;
    localparam logic [ByteW-1:0]   AsciiZero    = 8'h30;

    // up to four result words produced by one input word
    typedef struct packed {
        logic [CountW-1:0]                count;
        logic [ListDepth-1:0][ByteW-1:0]  bytes;
    } t_rlbc_burst;

endpackage

`default_nettype wire

@@ design/rlbc_step.sv @@
// run state and the per-word encode logic that builds the result list
`default_nettype none

module rlbc_step
    import rlbc_pkg::*;
#(
    parameter int MAX_RUN = MaxRunDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_move,
    input  wire logic [ByteW-1:0]   i_byte,
    input  wire logic               i_end,
    input  wire logic [ThrW-1:0]    i_thr,
    output t_rlbc_burst             o_burst
);

    logic [ByteW-1:0]   r_run_val;
    logic [RunLenW-1:0] r_run_len;
    logic [ByteW-1:0]   n_run_val;
    logic [RunLenW-1:0] n_run_len;

    logic               match;
    logic               close;
    logic               enc_a;
    logic               enc_b;
    logic [RunLenW-1:0] grown_len;
    logic [CountW-1:0]  cnt_a;
    logic [CountW-1:0]  cnt_b;
    logic [CountW-1:0]  j;
    logic [RunLenW-1:0] thr_ext;

    always_comb begin
        thr_ext   = RunLenW'(i_thr);
        match     = (r_run_len != '0) && (i_byte == r_run_val);
        grown_len = match ? (r_run_len + 1'b1) : RunLenW'(1);

        // previous run flushed when a different byte arrives
        enc_a = (r_run_len >= thr_ext);
        if (match || (r_run_len == '0)) begin
            cnt_a = '0;
        end else if (enc_a) begin
            cnt_a = CountW'(2);
        end else begin
            cnt_a = CountW'(r_run_len);
        end

        close = i_end || (grown_len >= RunLenW'(MAX_RUN)) || (grown_len >= RunCap);
        enc_b = (grown_len >= thr_ext);
        if (!close) begin
            cnt_b = '0;
        end else if (enc_b) begin
            cnt_b = CountW'(2);
        end else begin
            cnt_b = CountW'(grown_len);
        end

        o_burst.count = cnt_a + cnt_b;
        j = '0;
        for (int k = 0; k < ListDepth; k++) begin
            if (CountW'(k) < cnt_a) begin
                o_burst.bytes[k] = (enc_a && k == 1) ?
                                   (AsciiZero + ByteW'(r_run_len)) : r_run_val;
            end else begin
                j = CountW'(k) - cnt_a;
                o_burst.bytes[k] = (enc_b && j == CountW'(1)) ?
                                   (AsciiZero + ByteW'(grown_len)) : i_byte;
            end
        end

        n_run_val = i_byte;
        n_run_len = close ? '0 : grown_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_val <= '0;
            r_run_len <= '0;
        end else if (i_move) begin
            r_run_val <= n_run_val;
            r_run_len <= n_run_len;
        end
    end

endmodule

`default_nettype wire

@@ design/rlbc_outq.sv @@
// result list register, drained one word per cycle while i_stall is low
`default_nettype none

module rlbc_outq
    import rlbc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  t_rlbc_burst             i_burst,
    input  wire logic               i_stall,
    output logic                    o_free,
    output logic                    o_valid,
    output logic [ByteW-1:0]        o_out_byte,
    output logic                    o_out_last
);

    logic [ListDepth-1:0][ByteW-1:0] r_bytes;
    logic [CountW-1:0]               r_left;
    logic                            take;

    assign o_valid    = (r_left != '0);
    assign take       = o_valid && !i_stall;
    assign o_out_byte = r_bytes[0];
    assign o_out_last = (r_left == CountW'(1));
    // free once the final word of the current list leaves
    assign o_free     = (r_left == '0) || (o_out_last && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_burst.count;
        end else if (take) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
        end else if (take) begin
            for (int k = 0; k < ListDepth - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/run_length_byte_compressor.sv @@
// top level: input register, threshold register, encoder and output list
// an input word is held in the input register and encoded there once the output list is free;
// its result words are then loaded into the output list register and offered in order
// one input word per cycle while each word gives at most one result and i_stall is low; the
// output list (one word per cycle) sets the rate when a short run expands to several words
// synchronous active-low reset discards any open run, drops pending words, threshold 4
`default_nettype none

module run_length_byte_compressor
    import rlbc_pkg::*;
#(
    parameter int MAX_RUN = MaxRunDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [ByteW-1:0]   i_data_byte,
    input  wire logic               i_stream_end,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ByteW-1:0]        o_out_byte,
    output logic                    o_out_last,
    input  wire logic               i_cfg_we,
    input  wire logic [RunLenW-1:0] i_cfg_wdata
);

    logic               r_in_vld;
    logic [ByteW-1:0]   r_in_byte;
    logic               r_in_end;
    logic [RunLenW-1:0] r_min_run;
    logic [ThrW-1:0]    thr;
    logic               move;
    logic               q_free;
    logic               accept;
    t_rlbc_burst        burst;

    always_comb begin
        if (r_min_run < ThrFloor) begin
            thr = ThrW'(ThrFloor);
        end else if (r_min_run > ThrCeil) begin
            thr = ThrW'(ThrCeil);
        end else begin
            thr = ThrW'(r_min_run);
        end
    end

    assign move    = r_in_vld && q_free;
    assign o_stall = r_in_vld && !move;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run <= MinRunReset;
        end else if (i_cfg_we) begin
            r_min_run <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    rlbc_step #(
        .MAX_RUN (MAX_RUN)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (move),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_thr   (thr),
        .o_burst (burst)
    );

    rlbc_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (move),
        .i_burst    (burst),
        .i_stall    (i_stall),
        .o_free     (q_free),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    a_burst_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |-> (burst.count <= CountW'(ListDepth)))
        else $error("result list overflow");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (o_valid == $past(burst.count != '0)))
        else $error("loaded list not presented");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (thr >= ThrW'(ThrFloor)) && (thr <= ThrW'(ThrCeil)))
        else $error("threshold out of range");

endmodule

`default_nettype wire
